// ===== rtl/debounced_button_bit_editor_unit_defines.svh =====
// Assertion macros used by the checker file of the bit editor.
`ifndef DEBOUNCED_BUTTON_BIT_EDITOR_UNIT_DEFINES_SVH
`define DEBOUNCED_BUTTON_BIT_EDITOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define DBBE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bit editor check failed");

// Next-cycle implication, disabled while reset is held.
`define DBBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bit editor check failed");

`endif

// ===== rtl/dbbe_pkg.sv =====
package dbbe_pkg;

    typedef logic [6:0] t_seg7;
    typedef logic [8:0] t_count;

    localparam int NUM_BTN = 4;

    localparam int BTN_LEFT   = 0;
    localparam int BTN_RIGHT  = 1;
    localparam int BTN_TOGGLE = 2;
    localparam int BTN_CLEAR  = 3;

    localparam logic [7:0] LOCKOUT_RESET = 8'd20;
    localparam t_count     COUNT_MAX     = 9'd511;

    localparam t_seg7 SEG_CODE [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    // Tens digit of a six-bit value, found by comparison.
    function automatic logic [3:0] tens_of(input logic [5:0] v);
        logic [3:0] t;
        if (v >= 6'd60) begin
            t = 4'd6;
        end else if (v >= 6'd50) begin
            t = 4'd5;
        end else if (v >= 6'd40) begin
            t = 4'd4;
        end else if (v >= 6'd30) begin
            t = 4'd3;
        end else if (v >= 6'd20) begin
            t = 4'd2;
        end else if (v >= 6'd10) begin
            t = 4'd1;
        end else begin
            t = 4'd0;
        end
        return t;
    endfunction

    function automatic logic [3:0] units_of(input logic [5:0] v);
        logic [5:0] tens10;
        logic [5:0] rem;
        tens10 = 6'(tens_of(v)) * 6'd10;
        rem    = v - tens10;
        return rem[3:0];
    endfunction

    // Active-low segment code with the decimal point off.
    function automatic logic [7:0] seg_n(input logic [3:0] d);
        t_seg7 code;
        if (d < 4'd10) begin
            code = SEG_CODE[d];
        end else begin
            code = '0;
        end
        return ~{1'b0, code};
    endfunction

endpackage

// ===== rtl/debounced_button_bit_editor_unit.sv =====
// Debounced six-bit LED editor. Each request is one millisecond tick with the
// raw active-low levels of the left, right, toggle and clear buttons; each tick
// gives exactly one result with the LED pattern, cursor position, active-low
// seven-segment codes of the pattern's units and tens digits, and the presses
// accepted on that tick. A button change counts only once its tick count since
// the last accepted change exceeds the lockout register (reset 20), so nothing
// is accepted in the first lockout ticks after reset. A request is registered,
// then the debounce and edit update runs between that register and the result
// register; one request per cycle is sustained unless stalled. Write the
// lockout only while the unit is idle.
module debounced_button_bit_editor_unit #(
    parameter int LED_COUNT = 6
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_btn_left_n,
    input  logic       i_btn_right_n,
    input  logic       i_btn_toggle_n,
    input  logic       i_btn_clear_n,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [5:0] o_led_pattern,
    output logic [2:0] o_cursor_pos,
    output logic [7:0] o_seg_units_n,
    output logic [7:0] o_seg_tens_n,
    output logic [3:0] o_press_events
);

    localparam logic [2:0] CURSOR_MAX   = 3'(LED_COUNT - 1);
    localparam logic [5:0] PATTERN_MASK = 6'((1 << LED_COUNT) - 1);

    logic [7:0]            r_lockout_ms;
    logic                  r_in_valid;
    logic [3:0]            r_in_btn;
    logic                  r_out_valid;
    logic [3:0]            r_stable;
    logic [3:0]            n_stable;
    dbbe_pkg::t_count      r_since [dbbe_pkg::NUM_BTN];
    dbbe_pkg::t_count      n_since [dbbe_pkg::NUM_BTN];
    logic [2:0]            r_cursor;
    logic [2:0]            n_cursor;
    logic [5:0]            r_pattern;
    logic [5:0]            n_pattern;
    logic [3:0]            n_events;
    logic [5:0]            r_led_pattern;
    logic [2:0]            r_cursor_pos;
    logic [7:0]            r_seg_units_n;
    logic [7:0]            r_seg_tens_n;
    logic [3:0]            r_press_events;
    logic                  w_accept;
    logic                  w_advance;

    assign w_advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && r_out_valid && i_stall;
    assign w_accept  = i_valid && !o_stall;

    // Debounce and edit update for the registered tick.
    always_comb begin
        dbbe_pkg::t_count cnt;
        n_stable  = r_stable;
        n_events  = '0;
        n_cursor  = r_cursor;
        n_pattern = r_pattern;
        for (int i = 0; i < dbbe_pkg::NUM_BTN; i++) begin
            cnt = (r_since[i] < dbbe_pkg::COUNT_MAX) ? r_since[i] + 9'd1 : r_since[i];
            if ((r_in_btn[i] != r_stable[i]) && (cnt > {1'b0, r_lockout_ms})) begin
                n_stable[i] = r_in_btn[i];
                n_events[i] = !r_in_btn[i];
                cnt         = '0;
            end
            n_since[i] = cnt;
        end
        if (n_events[dbbe_pkg::BTN_LEFT] && (n_cursor > 3'd0)) begin
            n_cursor = n_cursor - 3'd1;
        end
        if (n_events[dbbe_pkg::BTN_RIGHT] && (n_cursor < CURSOR_MAX)) begin
            n_cursor = n_cursor + 3'd1;
        end
        if (n_events[dbbe_pkg::BTN_TOGGLE]) begin
            n_pattern = (n_pattern ^ (6'd1 << n_cursor)) & PATTERN_MASK;
        end
        if (n_events[dbbe_pkg::BTN_CLEAR]) begin
            n_pattern = '0;
            n_cursor  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lockout_ms <= dbbe_pkg::LOCKOUT_RESET;
        end else if (i_cfg_we) begin
            r_lockout_ms <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_stable    <= '1;
            r_cursor    <= '0;
            r_pattern   <= PATTERN_MASK;
            for (int i = 0; i < dbbe_pkg::NUM_BTN; i++) begin
                r_since[i] <= '0;
            end
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_stable    <= n_stable;
                r_cursor    <= n_cursor;
                r_pattern   <= n_pattern;
                for (int i = 0; i < dbbe_pkg::NUM_BTN; i++) begin
                    r_since[i] <= n_since[i];
                end
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_btn <= {i_btn_clear_n, i_btn_toggle_n, i_btn_right_n, i_btn_left_n};
        end
        if (w_advance) begin
            r_led_pattern  <= n_pattern;
            r_cursor_pos   <= n_cursor;
            r_seg_units_n  <= dbbe_pkg::seg_n(dbbe_pkg::units_of(n_pattern));
            r_seg_tens_n   <= dbbe_pkg::seg_n(dbbe_pkg::tens_of(n_pattern));
            r_press_events <= n_events;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_led_pattern  = r_led_pattern;
    assign o_cursor_pos   = r_cursor_pos;
    assign o_seg_units_n  = r_seg_units_n;
    assign o_seg_tens_n   = r_seg_tens_n;
    assign o_press_events = r_press_events;

endmodule

// ===== rtl/dbbe_checker.sv =====
`include "debounced_button_bit_editor_unit_defines.svh"

module dbbe_checker #(
    parameter int LED_COUNT = 6
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [5:0] o_led_pattern,
    input logic [2:0] o_cursor_pos,
    input logic [7:0] o_seg_units_n,
    input logic [7:0] o_seg_tens_n,
    input logic [3:0] o_press_events
);

    localparam logic [2:0] CURSOR_MAX   = 3'(LED_COUNT - 1);
    localparam logic [5:0] PATTERN_MASK = 6'((1 << LED_COUNT) - 1);

    logic [28:0] w_result;
    logic        w_stalled;
    logic        w_in_range;
    logic        w_clear_press;
    logic        w_cleared;

    assign w_result      = {o_led_pattern, o_cursor_pos, o_seg_units_n, o_seg_tens_n,
                            o_press_events};
    assign w_stalled     = o_valid && i_stall;
    assign w_in_range    = (o_cursor_pos <= CURSOR_MAX)
                           && ((o_led_pattern & ~PATTERN_MASK) == 6'd0);
    assign w_clear_press = o_valid && o_press_events[dbbe_pkg::BTN_CLEAR];
    assign w_cleared     = (o_led_pattern == 6'd0) && (o_cursor_pos == 3'd0);

    // A stalled result holds its value.
    `DBBE_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, w_stalled, o_valid && $stable(w_result))

    // The cursor never leaves the LED row and the pattern stays within it.
    `DBBE_ASSERT_NOW(a_in_range, i_clk, i_rst_n, o_valid, w_in_range)

    // A clear press leaves an empty pattern and the cursor at zero.
    `DBBE_ASSERT_NOW(a_clear, i_clk, i_rst_n, w_clear_press, w_cleared)

    // The decimal points stay dark.
    `DBBE_ASSERT_NOW(a_dp_off, i_clk, i_rst_n, o_valid, o_seg_units_n[7] && o_seg_tens_n[7])

endmodule

bind debounced_button_bit_editor_unit dbbe_checker #(
    .LED_COUNT(LED_COUNT)
) u_dbbe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_led_pattern (o_led_pattern),
    .o_cursor_pos  (o_cursor_pos),
    .o_seg_units_n (o_seg_units_n),
    .o_seg_tens_n  (o_seg_tens_n),
    .o_press_events(o_press_events)
);
